// ----- rtl/fbr_pkg.sv -----
`default_nettype none

package fbr_pkg;

    localparam int COUNT_W     = 17;
    localparam int FRAME_W     = 16;
    localparam int FRAME_SHIFT = 12;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 17'd65536;
    localparam logic [31:0]        TYPE_AVAILABLE    = 32'd1;

    localparam logic [1:0] REQ_MARK_USED = 2'd0;
    localparam logic [1:0] REQ_MARK_FREE = 2'd1;
    localparam logic [1:0] REQ_TEST      = 2'd2;
    localparam logic [1:0] REQ_RESERVE   = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [FRAME_W-1:0] frame;
        logic [63:0]        region_base;
        logic [63:0]        region_length;
        logic [31:0]        region_type;
    } t_req;

    typedef struct packed {
        logic               is_free;
        logic               out_of_range;
        logic [COUNT_W-1:0] frames_marked;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_OFFS,
        ST_WALK,
        ST_LAST,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/frame_bitmap_reserver_unit.sv -----
`default_nettype none

// Channel   Direction  Handshake             Payload
// request   in         start & !busy         i_req  (fbr_pkg::t_req)
// result    out        o_done, one cycle     o_rsp  (fbr_pkg::t_rsp)
// config    in         i_cfg_we              i_cfg_wdata (frame_count)
//
// A request keeps busy high from its accept edge through its o_done cycle; the bitmap words it
// touches are walked one a cycle through the map RAM (one word for an in-range single frame).
// A request that touches no word (frame out of range, skipped or empty region) skips the walk.
// After reset, busy stays high while the MAP_WORDS map words (2048 by default) are
// swept to all free; configuration writes are taken during that sweep.
// The receiver cannot stall: o_done marks the last busy cycle and lasts exactly one.
module frame_bitmap_reserver_unit #(
    parameter int NUM_FRAMES = 65536,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire fbr_pkg::t_req                i_req,
    output logic                              o_done,
    output fbr_pkg::t_rsp                     o_rsp,
    input  wire logic                         i_cfg_we,
    input  wire logic [fbr_pkg::COUNT_W-1:0]  i_cfg_wdata
);

    localparam int CW        = fbr_pkg::COUNT_W;
    localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    // exact reciprocal for dividing a CW-bit frame number by WORD_BITS
    localparam int SHIFT     = CW + BW;
    localparam int RECIP_W   = CW + 2;
    localparam int RECIP     = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W    = CW + RECIP_W;
    localparam int QW        = PROD_W - SHIFT;
    localparam int SHIFT_HI  = 64 - fbr_pkg::FRAME_SHIFT;

    fbr_pkg::t_state r_state;
    fbr_pkg::t_state n_state;

    logic [CW-1:0]        r_frame_count;
    logic [AW-1:0]        r_clr_addr;
    fbr_pkg::t_req        r_req;
    logic [1:0]           r_op;
    logic                 r_oor;
    logic [CW-1:0]        r_start;
    logic [CW-1:0]        r_end;
    logic [CW-1:0]        r_rem;
    logic [CW-1:0]        r_marked;
    logic [QW-1:0]        r_quo;
    logic [BW-1:0]        r_bit;
    logic [AW-1:0]        r_waddr;
    logic                 r_pend;
    logic [AW-1:0]        r_paddr;
    logic [WORD_BITS-1:0] r_pmask;
    logic                 r_is_free;

    logic [CW-1:0]        lim;
    logic [63:0]          sum;
    logic [SHIFT_HI-1:0]  start_pg;
    logic [SHIFT_HI-1:0]  end_pg;
    logic [CW-1:0]        start_c;
    logic [CW-1:0]        end_c;
    logic [CW-1:0]        frame_ext;
    logic                 in_range;
    logic [CW-1:0]        cnt;
    logic [PROD_W-1:0]    prod;
    logic [CW-1:0]        word_base;
    logic [BW:0]          avail;
    logic [BW:0]          take;
    logic [BW:0]          hi;
    logic [WORD_BITS-1:0] mask;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;

    // ---------------------------------------------------------------- datapath logic
    always_comb begin
        if (32'(r_frame_count) > 32'(NUM_FRAMES)) begin
            lim = CW'(NUM_FRAMES);
        end else begin
            lim = r_frame_count;
        end

        sum      = r_req.region_base + r_req.region_length;
        start_pg = r_req.region_base[63:fbr_pkg::FRAME_SHIFT];
        end_pg   = sum[63:fbr_pkg::FRAME_SHIFT];
        start_c  = (start_pg > SHIFT_HI'(lim)) ? lim : CW'(start_pg);
        end_c    = (end_pg > SHIFT_HI'(lim)) ? lim : CW'(end_pg);

        frame_ext = CW'(r_req.frame);
        in_range  = frame_ext < lim;

        cnt  = (r_start < r_end) ? (r_end - r_start) : '0;
        prod = PROD_W'(r_start) * PROD_W'(RECIP);

        word_base = CW'(32'(r_quo) * 32'(WORD_BITS));

        avail = (BW+1)'(WORD_BITS) - {1'b0, r_bit};
        take  = (r_rem < CW'(avail)) ? (BW+1)'(r_rem) : avail;
        hi    = {1'b0, r_bit} + take;
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = ((BW+1)'(i) >= {1'b0, r_bit}) && ((BW+1)'(i) < hi);
        end
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fbr_pkg::ST_CLEAR: begin
                if (r_clr_addr == AW'(MAP_WORDS - 1)) begin
                    n_state = fbr_pkg::ST_IDLE;
                end
            end
            fbr_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = fbr_pkg::ST_PREP;
                end
            end
            fbr_pkg::ST_PREP: n_state = fbr_pkg::ST_DIV;
            fbr_pkg::ST_DIV: begin
                if (cnt == '0) begin
                    n_state = fbr_pkg::ST_DONE;
                end else begin
                    n_state = fbr_pkg::ST_OFFS;
                end
            end
            fbr_pkg::ST_OFFS: n_state = fbr_pkg::ST_WALK;
            fbr_pkg::ST_WALK: begin
                if (r_rem == CW'(take)) begin
                    n_state = fbr_pkg::ST_LAST;
                end
            end
            fbr_pkg::ST_LAST: n_state = fbr_pkg::ST_DONE;
            fbr_pkg::ST_DONE: n_state = fbr_pkg::ST_IDLE;
            default:          n_state = fbr_pkg::ST_CLEAR;
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb begin
        busy   = (r_state != fbr_pkg::ST_IDLE);
        o_done = (r_state == fbr_pkg::ST_DONE);
        if (r_state == fbr_pkg::ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '1;
        end else begin
            mem_we    = r_pend && (r_op != fbr_pkg::REQ_TEST);
            mem_waddr = r_paddr;
            if (r_op == fbr_pkg::REQ_MARK_FREE) begin
                mem_wdata = mem_rdata | r_pmask;
            end else begin
                mem_wdata = mem_rdata & ~r_pmask;
            end
        end
    end

    assign o_rsp.is_free       = r_is_free;
    assign o_rsp.out_of_range  = r_oor;
    assign o_rsp.frames_marked = r_marked;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fbr_pkg::ST_CLEAR;
            r_clr_addr    <= '0;
            r_frame_count <= fbr_pkg::FRAME_COUNT_RESET;
            r_pend        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == fbr_pkg::ST_WALK);
            if (r_state == fbr_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            fbr_pkg::ST_IDLE: begin
                r_req <= i_req;
            end
            fbr_pkg::ST_PREP: begin
                r_op <= r_req.req_type;
                if (r_req.req_type == fbr_pkg::REQ_RESERVE) begin
                    r_oor <= 1'b0;
                    if (r_req.region_type == fbr_pkg::TYPE_AVAILABLE) begin
                        r_start <= '0;
                        r_end   <= '0;
                    end else begin
                        r_start <= start_c;
                        r_end   <= end_c;
                    end
                end else begin
                    r_oor   <= !in_range;
                    r_start <= frame_ext;
                    r_end   <= in_range ? (frame_ext + CW'(1)) : frame_ext;
                end
            end
            fbr_pkg::ST_DIV: begin
                r_rem     <= cnt;
                r_marked  <= (r_op == fbr_pkg::REQ_RESERVE) ? cnt : '0;
                r_quo     <= prod[SHIFT +: QW];
                r_is_free <= 1'b0;
            end
            fbr_pkg::ST_OFFS: begin
                r_bit   <= BW'(r_start - word_base);
                r_waddr <= AW'(r_quo);
            end
            fbr_pkg::ST_WALK: begin
                // issue read of this word; it is written back (or tested, for REQ_TEST) next cycle
                r_paddr <= r_waddr;
                r_pmask <= mask;
                r_waddr <= r_waddr + AW'(1);
                r_bit   <= '0;
                r_rem   <= r_rem - CW'(take);
            end
            default: begin
            end
        endcase
        if (r_pend && (r_op == fbr_pkg::REQ_TEST)) begin
            r_is_free <= |(mem_rdata & r_pmask);
        end
    end

    fbr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_waddr),
        .o_rdata (mem_rdata)
    );

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbr_pkg::ST_IDLE) |-> !mem_we)
        else $error("map written while idle");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !r_pend)
        else $error("write still pending when idle");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.out_of_range) |->
            (o_rsp.frames_marked == '0) && !o_rsp.is_free)
        else $error("out of range result carries data");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == fbr_pkg::ST_PREP))
        else $error("accepted transfer not processed");
`endif

endmodule

`default_nettype wire

// ----- rtl/fbr_ram.sv -----
`default_nettype none

module fbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
